// File: src/crg_pkg.sv
// Shared types, register indexes and fixed-point helpers for the camera ray generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package crg_pkg;

   localparam int QW    = 32;  // Q16.16 word
   localparam int UW    = 18;  // normalized w and u component, magnitude <= 1.0
   localparam int VW    = 19;  // v component, v = w x u
   localparam int DW    = 33;  // eye minus look
   localparam int FW    = 31;  // focal distance
   localparam int WIDEW = 54;  // widest product sum handed to rounding

   typedef enum logic [2:0] {
      CSR_EYE_X, CSR_EYE_Y, CSR_EYE_Z,
      CSR_LOOK_X, CSR_LOOK_Y, CSR_LOOK_Z,
      CSR_FOCAL, CSR_MODE
   } csr_index_type;

   typedef logic signed [UW-1:0] unit_type;
   typedef logic signed [VW-1:0] vcomp_type;
   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [QW-1:0] word_type;

   typedef struct packed {
      unit_type  [2:0] w;
      unit_type  [2:0] u;
      vcomp_type [2:0] v;
      logic            ok;
   } basis_type;

   // Q22.32 to Q22.16: add one half and floor
   function automatic logic signed [WIDEW-17:0] round_q16(input logic signed [WIDEW-1:0] x);
      logic signed [WIDEW-1:0] t;
      t = x + WIDEW'(32768);
      return t[WIDEW-1:16];
   endfunction

   function automatic word_type sat32(input logic signed [WIDEW-1:0] x);
      if (x > WIDEW'(64'sd2147483647))
         return word_type'(32'h7FFF_FFFF);
      else if (x < -WIDEW'(64'sd2147483648))
         return word_type'(32'h8000_0000);
      else
         return x[QW-1:0];
   endfunction

endpackage
`default_nettype wire

// File: src/crg_norm.sv
// Sequential vector normalizer: block scaling, sum of squares, bit-serial square root and
// restoring division, one step a cycle. Depends on crg_pkg.
`default_nettype none
module crg_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  crg_pkg::diff_type [2:0] vec_in,
   output crg_pkg::unit_type [2:0] vec_out,
   output logic                   ok,
   output logic                   done
);
   import crg_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MAX, S_SCALE, S_SQ, S_ROOT, S_DIV} state_type;

   state_type             state_ff;
   diff_type  [2:0]       vec_ff;
   logic      [DW-1:0]    mx_ff;
   logic signed [30:0]    c_ff [3];
   logic      [1:0]       idx_ff;
   logic      [61:0]      sum_ff;
   logic      [63:0]      n_ff;
   logic      [63:0]      res_ff;
   logic      [63:0]      bit_ff;
   logic      [32:0]      rem_ff;
   logic      [46:0]      quo_ff;
   logic      [5:0]       cnt_ff;
   unit_type  [2:0]       out_ff;
   logic                  ok_ff;
   logic                  done_ff;

   logic      [DW-1:0]    mag [3];
   logic      [DW-1:0]    mx_in;
   logic      [5:0]       msb;
   logic signed [30:0]    scaled [3];
   logic      [61:0]      sum_in;
   logic signed [61:0]    sq;
   logic      [63:0]      trial;
   logic                  root_ge;
   logic      [32:0]      rem_sh;
   logic                  div_ge;
   logic      [46:0]      dvd [3];
   logic      [46:0]      quo_in;
   logic      [46:0]      q_neg;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = vec_ff[i][DW-1] ? DW'(-vec_ff[i]) : DW'(vec_ff[i]);
      end
      mx_in = mag[0];
      if (mag[1] > mx_in) mx_in = mag[1];
      if (mag[2] > mx_in) mx_in = mag[2];
      msb = '0;
      for (int b = 0; b < DW; b++) begin
         if (mx_ff[b]) msb = 6'(b);
      end
      for (int i = 0; i < 3; i++) begin
         if (msb >= 6'd30)
            scaled[i] = 31'(vec_ff[i] >>> (msb - 6'd29));
         else
            scaled[i] = 31'(vec_ff[i] <<< (6'd29 - msb));
         dvd[i] = 47'({(c_ff[i][30] ? 31'(-c_ff[i]) : c_ff[i]), 16'd0});
      end
      sq      = c_ff[idx_ff] * c_ff[idx_ff];
      sum_in  = sum_ff + 62'(sq);
      trial   = res_ff + bit_ff;
      root_ge = n_ff >= trial;
      rem_sh  = {rem_ff[31:0], quo_ff[46]};
      div_ge  = rem_sh >= {1'b0, res_ff[31:0]};
      quo_in  = {quo_ff[45:0], div_ge};
      q_neg   = -quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            vec_ff   <= vec_in;
            state_ff <= S_MAX;
         end else begin
            unique case (state_ff)
               S_IDLE: ;
               S_MAX: begin
                  mx_ff    <= mx_in;
                  state_ff <= S_SCALE;
               end
               S_SCALE: begin
                  if (mx_ff == '0) begin
                     out_ff   <= '0;
                     ok_ff    <= 1'b0;
                     done_ff  <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     for (int i = 0; i < 3; i++) c_ff[i] <= scaled[i];
                     sum_ff   <= '0;
                     idx_ff   <= '0;
                     state_ff <= S_SQ;
                  end
               end
               S_SQ: begin
                  sum_ff <= sum_in;
                  if (idx_ff == 2'd2) begin
                     n_ff     <= {2'b00, sum_in};
                     res_ff   <= '0;
                     bit_ff   <= 64'h4000_0000_0000_0000;
                     state_ff <= S_ROOT;
                  end else begin
                     idx_ff <= idx_ff + 2'd1;
                  end
               end
               S_ROOT: begin
                  if (root_ge) begin
                     n_ff   <= n_ff - trial;
                     res_ff <= (res_ff >> 1) + bit_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
                  if (bit_ff[0]) begin
                     idx_ff   <= '0;
                     rem_ff   <= '0;
                     quo_ff   <= dvd[0];
                     cnt_ff   <= '0;
                     state_ff <= S_DIV;
                  end
               end
               S_DIV: begin
                  rem_ff <= div_ge ? rem_sh - {1'b0, res_ff[31:0]} : rem_sh;
                  quo_ff <= quo_in;
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == 6'd46) begin
                     out_ff[idx_ff] <= c_ff[idx_ff][30] ? q_neg[UW-1:0] : quo_in[UW-1:0];
                     if (idx_ff == 2'd2) begin
                        ok_ff    <= 1'b1;
                        done_ff  <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff <= idx_ff + 2'd1;
                        rem_ff <= '0;
                        quo_ff <= dvd[idx_ff + 2'd1];
                        cnt_ff <= '0;
                     end
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign vec_out = out_ff;
   assign ok      = ok_ff;
   assign done    = done_ff;

endmodule
`default_nettype wire

// File: src/crg_basis.sv
// Camera basis sequencer: w = norm(eye - look), u = norm(up x w), v = w x u.
// Depends on crg_pkg and crg_norm.
`default_nettype none
module crg_basis (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  crg_pkg::diff_type [2:0] diff,
   output crg_pkg::basis_type      basis,
   output logic                    busy
);
   import crg_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_W_GO, B_W_RUN, B_U_GO, B_U_RUN, B_V} state_type;

   state_type        state_ff;
   unit_type  [2:0]  w_ff;
   unit_type  [2:0]  u_ff;
   vcomp_type [2:0]  v_ff;
   logic             okw_ff;
   logic             oku_ff;
   logic      [2:0]  step_ff;
   logic signed [35:0] acc_ff;

   logic             norm_start;
   diff_type  [2:0]  norm_vec;
   unit_type  [2:0]  norm_out;
   logic             norm_ok;
   logic             norm_done;
   unit_type         op_a;
   unit_type         op_b;
   logic signed [35:0] prod;
   logic signed [WIDEW-1:0] cross_sum;
   logic signed [WIDEW-17:0] cross_rnd;

   crg_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .vec_in  (norm_vec),
      .vec_out (norm_out),
      .ok      (norm_ok),
      .done    (norm_done)
   );

   always_comb begin
      norm_start = (state_ff == B_W_GO) || (state_ff == B_U_GO);
      if (state_ff == B_W_GO) begin
         norm_vec = diff;
      end else begin
         norm_vec[0] = DW'(w_ff[2]);
         norm_vec[1] = '0;
         norm_vec[2] = -DW'(w_ff[0]);
      end
      case (step_ff)
         3'd0:    begin op_a = w_ff[1]; op_b = u_ff[2]; end
         3'd1:    begin op_a = w_ff[2]; op_b = u_ff[1]; end
         3'd2:    begin op_a = w_ff[2]; op_b = u_ff[0]; end
         3'd3:    begin op_a = w_ff[0]; op_b = u_ff[2]; end
         3'd4:    begin op_a = w_ff[0]; op_b = u_ff[1]; end
         default: begin op_a = w_ff[1]; op_b = u_ff[0]; end
      endcase
      prod      = op_a * op_b;
      cross_sum = WIDEW'(acc_ff) - WIDEW'(prod);
      cross_rnd = round_q16(cross_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         okw_ff   <= 1'b0;
         oku_ff   <= 1'b0;
      end else if (start) begin
         state_ff <= B_W_GO;
      end else begin
         unique case (state_ff)
            B_IDLE: ;
            B_W_GO: state_ff <= B_W_RUN;
            B_W_RUN: begin
               if (norm_done) begin
                  w_ff     <= norm_out;
                  okw_ff   <= norm_ok;
                  state_ff <= B_U_GO;
               end
            end
            B_U_GO: state_ff <= B_U_RUN;
            B_U_RUN: begin
               if (norm_done) begin
                  u_ff     <= norm_out;
                  oku_ff   <= norm_ok;
                  step_ff  <= '0;
                  state_ff <= B_V;
               end
            end
            B_V: begin
               if (!step_ff[0]) begin
                  acc_ff <= prod;
               end else begin
                  v_ff[step_ff[2:1]] <= cross_rnd[VW-1:0];
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd5) state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign basis = '{w: w_ff, u: u_ff, v: v_ff, ok: okw_ff & oku_ff};
   assign busy  = start || (state_ff != B_IDLE);

endmodule
`default_nettype wire

// File: src/crg_pipe.sv
// Four-stage ray pipeline: capture, products, sum and round, offset and saturate.
// Depends on crg_pkg.
`default_nettype none
module crg_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  crg_pkg::word_type       screen_u,
   input  crg_pkg::word_type       screen_v,
   input  crg_pkg::basis_type      basis,
   input  crg_pkg::word_type [2:0] eye,
   input  logic [crg_pkg::FW-1:0]  focal,
   input  logic                    mode,
   output logic                    out_valid,
   input  logic                    out_ready,
   output crg_pkg::word_type [2:0] ray_start,
   output crg_pkg::word_type [2:0] ray_heading,
   output logic                    degenerate
);
   import crg_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;
   word_type su_ff, sv_ff;
   logic signed [49:0] pu_ff [3];
   logic signed [50:0] pv_ff [3];
   logic signed [49:0] pf_ff [3];
   logic signed [WIDEW-17:0] rnd_ff [3];
   word_type [2:0] start_ff;
   word_type [2:0] head_ff;
   logic           deg_ff;

   logic signed [WIDEW-1:0] sum [3];
   logic signed [WIDEW-1:0] off [3];

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1 && !hold;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = WIDEW'(pu_ff[i]) + WIDEW'(pv_ff[i]) - (mode ? WIDEW'(pf_ff[i]) : '0);
         off[i] = WIDEW'(eye[i]) + WIDEW'(rnd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid && in_ready;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         su_ff <= screen_u;
         sv_ff <= screen_v;
      end
      if (adv2) begin
         for (int i = 0; i < 3; i++) begin
            pu_ff[i] <= basis.u[i] * su_ff;
            pv_ff[i] <= basis.v[i] * sv_ff;
            pf_ff[i] <= basis.w[i] * $signed({1'b0, focal});
         end
      end
      if (adv3) begin
         for (int i = 0; i < 3; i++) rnd_ff[i] <= round_q16(sum[i]);
      end
      if (adv4) begin
         for (int i = 0; i < 3; i++) begin
            if (mode) begin
               start_ff[i] <= eye[i];
               head_ff[i]  <= sat32(WIDEW'(rnd_ff[i]));
            end else begin
               start_ff[i] <= sat32(off[i]);
               head_ff[i]  <= sat32(-WIDEW'(basis.w[i]));
            end
         end
         deg_ff <= !basis.ok;
      end
   end

   assign out_valid   = v4_ff;
   assign ray_start   = start_ff;
   assign ray_heading = head_ff;
   assign degenerate  = deg_ff;

endmodule
`default_nettype wire

// File: src/camera_ray_generation.sv
// Pinhole camera ray generator, top level: register file, basis sequencer, ray pipeline.
// Depends on crg_pkg, crg_norm, crg_basis and crg_pipe.
//
// Use: write the eye and look-at points, focal distance and projection mode on the csr
// channel, then stream screen words (screen_u, screen_v, Q16.16) in on req_ and take one
// ray word per input on rsp_. The camera basis depends only on the eye and look-at
// registers; it is rebuilt by a sequential unit after reset and after every write to one
// of them. The rebuild runs two normalizations, each a 32-step square root and three
// 47-step divisions, and req_tready stays low until it is done.
// Writes to focal distance or mode need no rebuild.
// A screen word goes through the capture, products, round and offset registers to rsp_.
// Throughput: one word per cycle unless held; each multiply has its own products lane.
// Stall: rsp_tready low holds the last stage; the stages behind it keep filling bubbles,
// and req_tready drops only once all four are full. Nothing is lost or repeated.
// Reset: registers return to eye (0,0,0), look (0,0,-1), focal 1.0, perspective; the
// pipeline empties and the basis rebuild starts.
`default_nettype none
module camera_ray_generation (
   input  logic          clock,
   input  logic          reset,
   // screen word: [31:0] screen_u, [63:32] screen_v
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,
   // ray word: [31:0] start_x, [63:32] start_y, [95:64] start_z,
   // [127:96] heading_x, [159:128] heading_y, [191:160] heading_z
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [191:0]  rsp_tdata,
   // [0] degenerate
   output logic          rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import crg_pkg::*;

   word_type [2:0]  eye_ff;
   word_type [2:0]  look_ff;
   logic [FW-1:0]   focal_ff;
   logic            mode_ff;
   logic            rebuild_ff;

   diff_type  [2:0] diff;
   basis_type       basis;
   logic            busy;
   word_type  [2:0] ray_start;
   word_type  [2:0] ray_heading;
   logic            degenerate;

   assign csr_ready = 1'b1;

   // register writes; any eye or look-at change kicks off a basis rebuild
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff     <= '0;
         look_ff[0] <= '0;
         look_ff[1] <= '0;
         look_ff[2] <= word_type'(32'hFFFF_0000);
         focal_ff   <= FW'(65536);
         mode_ff    <= 1'b1;
         rebuild_ff <= 1'b1;
      end else begin
         rebuild_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_EYE_X:  begin eye_ff[0]  <= csr_data; rebuild_ff <= 1'b1; end
               CSR_EYE_Y:  begin eye_ff[1]  <= csr_data; rebuild_ff <= 1'b1; end
               CSR_EYE_Z:  begin eye_ff[2]  <= csr_data; rebuild_ff <= 1'b1; end
               CSR_LOOK_X: begin look_ff[0] <= csr_data; rebuild_ff <= 1'b1; end
               CSR_LOOK_Y: begin look_ff[1] <= csr_data; rebuild_ff <= 1'b1; end
               CSR_LOOK_Z: begin look_ff[2] <= csr_data; rebuild_ff <= 1'b1; end
               CSR_FOCAL:  focal_ff <= csr_data[FW-1:0];
               CSR_MODE:   mode_ff  <= csr_data[0];
            endcase
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) diff[i] = DW'(eye_ff[i]) - DW'(look_ff[i]);
   end

   crg_basis u_basis (
      .clock (clock),
      .reset (reset),
      .start (rebuild_ff),
      .diff  (diff),
      .basis (basis),
      .busy  (busy)
   );

   crg_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .hold        (busy),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .screen_u    (req_tdata[31:0]),
      .screen_v    (req_tdata[63:32]),
      .basis       (basis),
      .eye         (eye_ff),
      .focal       (focal_ff),
      .mode        (mode_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .ray_start   (ray_start),
      .ray_heading (ray_heading),
      .degenerate  (degenerate)
   );

   assign rsp_tdata = {ray_heading[2], ray_heading[1], ray_heading[0],
                       ray_start[2], ray_start[1], ray_start[0]};
   assign rsp_tuser = degenerate;

endmodule
`default_nettype wire

// File: test/camera_ray_generation_tb.sv
// Testbench for camera_ray_generation: streams screen words through several camera set-ups
// and checks every ray word against a typed value or an in-bench fixed-point camera model.
// Depends on crg_pkg and the camera_ray_generation RTL.
`timescale 1ns / 100ps
module camera_ray_generation_tb;
   import crg_pkg::*;

   localparam logic MODE_ORTHO = 1'b0;
   localparam logic MODE_PERSP = 1'b1;
   localparam int   N_RANDOM_PHASES = 12;
   localparam int   ITEMS_PER_PHASE = 150;

   typedef longint vec3_type [3];

   typedef struct {
      logic [31:0]  su;
      logic [31:0]  sv;
      bit           typed;
      logic [191:0] ray;   // {heading z,y,x, start z,y,x}
      logic         degen;
   } screen_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [191:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   // shadow of the camera registers
   logic [31:0]   cam_eye [3];
   logic [31:0]   cam_look [3];
   logic [30:0]   cam_focal;
   logic          cam_mode;

   logic [192:0]  rays_due [$];   // {degenerate, ray word}
   int            failures = 0;
   int            burst_left = 0;
   bit            hold_req = 1'b0;   // request for one long receiver stall
   bit            hold_off = 1'b0;   // receiver held off while set

   screen_row_type screen_rows [9];

   camera_ray_generation dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- camera model
   function automatic longint sext(input logic [31:0] x);
      return longint'(signed'(x));
   endfunction

   function automatic longint magn(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // floor square root, bit by bit
   function automatic longint floor_sqrt(input longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   // block-scale so the largest magnitude sits in [2^29, 2^30), then divide by the length
   function automatic bit to_unit(input vec3_type a, output vec3_type o);
      longint mx, sum, len;
      longint c [3];
      int down, up;
      mx = 0; sum = 0; down = 0; up = 0;
      for (int i = 0; i < 3; i++) if (magn(a[i]) > mx) mx = magn(a[i]);
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return 1'b0;
      end
      while (mx >= (64'sd1 <<< 30)) begin mx = mx >>> 1; down++; end
      while (mx < (64'sd1 <<< 29)) begin mx = mx <<< 1; up++; end
      for (int i = 0; i < 3; i++) begin
         c[i] = (a[i] >>> down) <<< up;
         sum += c[i] * c[i];
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) o[i] = (c[i] * 65536) / len;
      return 1'b1;
   endfunction

   function automatic longint to_q16(input longint x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic logic [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic logic [192:0] trace_ray(input logic [31:0] su_w, input logic [31:0] sv_w);
      vec3_type diff, w, cr, u;
      longint v [3];
      longint su, sv, plane;
      logic [31:0] start [3];
      logic [31:0] heading [3];
      bit ok;
      su = sext(su_w); sv = sext(sv_w);
      for (int i = 0; i < 3; i++) diff[i] = sext(cam_eye[i]) - sext(cam_look[i]);
      ok = to_unit(diff, w);
      cr[0] = w[2]; cr[1] = 0; cr[2] = -w[0];
      ok = to_unit(cr, u) && ok;
      v[0] = to_q16(w[1] * u[2] - w[2] * u[1]);
      v[1] = to_q16(w[2] * u[0] - w[0] * u[2]);
      v[2] = to_q16(w[0] * u[1] - w[1] * u[0]);
      for (int i = 0; i < 3; i++) begin
         plane = u[i] * su + v[i] * sv;
         if (cam_mode == MODE_PERSP) begin
            start[i]   = clamp32(sext(cam_eye[i]));
            heading[i] = clamp32(to_q16(plane - w[i] * longint'(cam_focal)));
         end else begin
            start[i]   = clamp32(sext(cam_eye[i]) + to_q16(plane));
            heading[i] = clamp32(-w[i]);
         end
      end
      return {~ok, heading[2], heading[1], heading[0], start[2], start[1], start[0]};
   endfunction

   // ---------------------------------------------------------------- drivers
   // a mix of full-range, small, extreme and mid-sized Q16.16 values
   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
         2: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom) >>> $urandom_range(4, 20));
      endcase
   endfunction

   // csr_valid stays high across back-to-back writes; set_camera drops it at the end
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx) inside
         CSR_EYE_X, CSR_EYE_Y, CSR_EYE_Z:    cam_eye[int'(idx)] = value;
         CSR_LOOK_X, CSR_LOOK_Y, CSR_LOOK_Z: cam_look[int'(idx) - 3] = value;
         CSR_FOCAL:                          cam_focal = value[30:0];
         CSR_MODE:                           cam_mode = value[0];
      endcase
   endtask

   // hold off until every ray is home
   task automatic drain();
      while (rays_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_camera(input logic [31:0] ex, ey, ez, lx, ly, lz, focal, mode);
      drain();
      csr_write(CSR_EYE_X, ex);  csr_write(CSR_EYE_Y, ey);  csr_write(CSR_EYE_Z, ez);
      csr_write(CSR_LOOK_X, lx); csr_write(CSR_LOOK_Y, ly); csr_write(CSR_LOOK_Z, lz);
      csr_write(CSR_FOCAL, focal);
      csr_write(CSR_MODE, mode);
      csr_valid <= 1'b0;
   endtask

   // send one screen word in bursts; the expected ray is booked once the word is taken
   task automatic send_screen(input logic [31:0] su, sv, input bit typed,
                              input logic [192:0] typed_ray);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sv, su};
      do @(posedge clock); while (!req_tready);
      rays_due.push_back(typed ? typed_ray : trace_ray(su, sv));
      burst_left--;
   endtask

   task automatic send_random(input int count);
      for (int k = 0; k < count; k++) send_screen(pick_q16(), pick_q16(), 1'b0, '0);
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   // ---------------------------------------------------------------- receiver
   // stall on a pattern of its own, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: rsp_tready <= 1'b0;
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   initial begin
      wait (hold_req);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   // ---------------------------------------------------------------- checker
   string field_name [6] = '{"ray_start_x", "ray_start_y", "ray_start_z",
                             "ray_heading_x", "ray_heading_y", "ray_heading_z"};

   always @(posedge clock) begin
      logic [192:0] due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rays_due.size() == 0) begin
            $error("ray word with no screen word outstanding");
            failures++;
         end else begin
            due = rays_due.pop_front();
            for (int f = 0; f < 6; f++)
               if (due[32*f +: 32] !== rsp_tdata[32*f +: 32]) begin
                  $error("%s: expected %h, got %h", field_name[f], due[32*f +: 32],
                         rsp_tdata[32*f +: 32]);
                  failures++;
               end
            if (due[192] !== rsp_tuser) begin
               $error("degenerate: expected %b, got %b", due[192], rsp_tuser);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- run limit
   initial begin
      #6_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int waited;
      // defaults after reset: w = +z, u = +x, v = +y, so heading = (U, V, -1)
      screen_rows[0] = '{32'h0, 32'h0, 1'b1,
                         {32'hFFFF0000, 32'h0, 32'h0, 96'h0}, 1'b0};
      screen_rows[1] = '{32'h0001_0000, 32'hFFFF_0000, 1'b1,
                         {32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 96'h0}, 1'b0};
      screen_rows[2] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                         {32'hFFFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 96'h0}, 1'b0};
      screen_rows[3] = '{32'h8000_0000, 32'h8000_0000, 1'b1,
                         {32'hFFFF0000, 32'h80000000, 32'h80000000, 96'h0}, 1'b0};
      screen_rows[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, 1'b0};
      screen_rows[5] = '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0, 1'b0};
      screen_rows[6] = '{32'h0000_8000, 32'h0000_8000, 1'b0, '0, 1'b0};
      screen_rows[7] = '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0, 1'b0};
      screen_rows[8] = '{32'hFFFF_8000, 32'h0000_7FFF, 1'b0, '0, 1'b0};

      cam_eye  = '{32'h0, 32'h0, 32'h0};
      cam_look = '{32'h0, 32'h0, 32'hFFFF_0000};
      cam_focal = 31'h0001_0000;
      cam_mode  = MODE_PERSP;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset camera, extremes of the screen plane
      foreach (screen_rows[r])
         send_screen(screen_rows[r].su, screen_rows[r].sv, screen_rows[r].typed,
                     {screen_rows[r].degen, screen_rows[r].ray});
      req_tvalid <= 1'b0;
      burst_left = 0;

      // eye on the look-at point: no w, everything degenerate
      set_camera(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, MODE_PERSP);
      send_random(4);
      // looking straight down the y axis: up x w vanishes
      set_camera(32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'hFFFB_0000, 32'h0,
                 32'h0002_0000, MODE_ORTHO);
      send_random(4);
      // extreme corners, orthographic, mode word with spare bits set, focal with bit 31
      set_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_random(4);
      set_camera(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_random(4);
      set_camera(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001, 32'h0, 32'h1);
      send_random(4);

      // random cameras; the first one also sits through a long receiver stall
      for (int p = 0; p < N_RANDOM_PHASES; p++) begin
         logic [31:0] ex, ey, ez;
         ex = pick_q16(); ey = pick_q16(); ez = pick_q16();
         if ($urandom_range(0, 7) == 0)
            set_camera(ex, ey, ez, ex, ey, ez, $urandom, $urandom);
         else
            set_camera(ex, ey, ez, pick_q16(), pick_q16(), pick_q16(), $urandom, $urandom);
         if (p == 0) hold_req = 1'b1;
         send_random(ITEMS_PER_PHASE);
      end

      waited = 0;
      while (rays_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (failures == 0 && rays_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
